[rtl/sbbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbbt_pkg
// shared types, codes and sizes for the submission byte budget tracker
// ----------------------------------------------------------------------------
package sbbt_pkg;

  localparam int unsigned Slots = 8;
  localparam int unsigned PagesPerSlot = 16;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned PageW = (PagesPerSlot > 1) ? $clog2(PagesPerSlot) : 1;
  localparam int unsigned PcW = $clog2(PagesPerSlot + 1);
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned MemW = SlotW + PageW;

  localparam logic [63:0] RstMaxInflight = 64'd268435456;
  localparam logic [63:0] RstMaxPerSub   = 64'd67108864;
  localparam logic [7:0]  RstMaxSubs     = 8'd8;

  localparam logic [1:0] CfgMaxInflight = 2'd0;
  localparam logic [1:0] CfgMaxPerSub   = 2'd1;
  localparam logic [1:0] CfgMaxSubs     = 2'd2;

  localparam logic [31:0] BufMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    SLOT_EMPTY     = 2'd0,
    SLOT_ENCODING  = 2'd1,
    SLOT_SUBMITTED = 2'd2
  } slot_state_e;

  typedef enum logic [3:0] {
    REQ_BEGIN    = 4'd0,
    REQ_RESERVE  = 4'd1,
    REQ_CANCEL   = 4'd2,
    REQ_RECORD   = 4'd3,
    REQ_SUBMIT   = 4'd4,
    REQ_COMPLETE = 4'd5,
    REQ_ABANDON  = 4'd6,
    REQ_QUERY    = 4'd7,
    REQ_CLEAR    = 4'd8
  } req_e;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_INVALID_CFG  = 4'd1,
    ST_INVALID_ID   = 4'd2,
    ST_ALREADY      = 4'd3,
    ST_NOT_FOUND    = 4'd4,
    ST_WRONG_STATE  = 4'd5,
    ST_SUB_LIMIT    = 4'd6,
    ST_INFLIGHT_CAP = 4'd7,
    ST_SUB_CAP      = 4'd8,
    ST_OVERFLOW     = 4'd9,
    ST_PAGE_LIMIT   = 4'd10,
    ST_LOG_EXCEEDS  = 4'd11,
    ST_CANCEL_MIS   = 4'd12
  } status_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_LOOKUP,
    C_EXEC,
    C_RESP
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch request
    logic lookup;   // register id match and page read
    logic exec;     // evaluate and commit
    logic clear;    // clear all
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dummy_ok;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/sbbt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbbt_ctrl
// sequencer: capture, lookup, execute, respond
// ----------------------------------------------------------------------------
module sbbt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output sbbt_pkg::dp_cmd_t     cmd_o
);
  import sbbt_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      C_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = C_LOOKUP;
        end
      end
      C_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d = C_EXEC;
      end
      C_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = C_RESP;
      end
      C_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/sbbt_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbbt_datapath
// slot table, page memory, totals and the command checks
// ----------------------------------------------------------------------------
module sbbt_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  sbbt_pkg::dp_cmd_t      cmd_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_addr_i,
  input  wire logic [63:0]       cfg_data_i,
  input  wire logic [3:0]        req_type_i,
  input  wire logic [63:0]       submission_id_i,
  input  wire logic [63:0]       byte_amount_i,
  output logic [3:0]             status_o,
  output logic [63:0]            total_reserved_o,
  output logic [63:0]            total_logical_o,
  output logic [63:0]            peak_reserved_o,
  output logic [63:0]            peak_logical_o,
  output logic [3:0]             encoding_count_o,
  output logic [3:0]             submitted_count_o,
  output logic [3:0]             peak_active_o,
  output logic [1:0]             entry_state_o,
  output logic [63:0]            entry_reserved_o,
  output logic [63:0]            entry_logical_o,
  output logic [4:0]             entry_pages_o
);
  import sbbt_pkg::*;

  // configuration
  logic [63:0] max_inf_q, max_sub_q;
  logic [7:0]  max_cnt_q;

  // slot table
  slot_state_e     sst_q [Slots];
  logic [63:0]     sid_q [Slots];
  logic [63:0]     srs_q [Slots];
  logic [63:0]     slg_q [Slots];
  logic [PcW-1:0]  spc_q [Slots];
  logic [31:0]     sbc_q [Slots];
  logic [63:0]     page_mem [Slots*PagesPerSlot];

  logic [63:0]     inf_r_q, inf_l_q, pk_r_q, pk_l_q;
  logic [CntW-1:0] enc_q, sub_q, pk_a_q;

  // captured request
  logic [3:0]  req_q;
  logic [63:0] id_q, amt_q;

  // lookup results
  logic             hit_q, free_ok_q;
  logic [SlotW-1:0] hs_q, fs_q;
  logic [63:0]      last_q;

  logic [3:0] status_q;

  // id match and free slot search
  logic             hit_c, free_c;
  logic [SlotW-1:0] hs_c, fs_c;
  always_comb begin
    hit_c = 1'b0;
    free_c = 1'b0;
    hs_c = '0;
    fs_c = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (sst_q[i] != SLOT_EMPTY && sid_q[i] == id_q && id_q != 64'd0) begin
        hit_c = 1'b1;
        hs_c = SlotW'(i);
      end
      if (sst_q[i] == SLOT_EMPTY) begin
        free_c = 1'b1;
        fs_c = SlotW'(i);
      end
    end
  end

  // page read address: last page of the matched slot
  logic [PcW-1:0]  pc_hit;
  logic [PageW-1:0] pidx;
  assign pc_hit = spc_q[hs_c];
  assign pidx = PageW'(pc_hit - PcW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      last_q <= page_mem[{hs_c, pidx}];
    end
  end

  // execute stage evaluation
  logic cfg_ok;
  assign cfg_ok = (max_inf_q != 0) && (max_sub_q != 0) && (max_sub_q <= max_inf_q) &&
                  (max_cnt_q >= 8'd1) && ({56'd0, max_cnt_q} <= 64'(Slots));

  slot_state_e    es;
  logic [63:0]    er, el;
  logic [PcW-1:0] ep;
  logic [64:0]    nr, ni, nl, nil;
  logic [CntW:0]  act;
  logic [3:0]     st;
  always_comb begin
    es = sst_q[hs_q];
    er = srs_q[hs_q];
    el = slg_q[hs_q];
    ep = spc_q[hs_q];
    nr = {1'b0, er} + {1'b0, amt_q};
    ni = {1'b0, inf_r_q} + {1'b0, amt_q};
    nl = {1'b0, el} + {1'b0, amt_q};
    nil = {1'b0, inf_l_q} + {1'b0, amt_q};
    act = {1'b0, enc_q} + {1'b0, sub_q};
    st = ST_OK;
    if (req_q == REQ_CLEAR) st = ST_OK;
    else if (req_q > REQ_CLEAR) st = ST_WRONG_STATE;
    else if (!cfg_ok) st = ST_INVALID_CFG;
    else if (id_q == 0) st = ST_INVALID_ID;
    else if (req_q == REQ_BEGIN) begin
      if (hit_q) st = ST_ALREADY;
      else if (64'(act) >= {56'd0, max_cnt_q}) st = ST_SUB_LIMIT;
      else if (!free_ok_q) st = ST_SUB_LIMIT;
    end else if (!hit_q) st = ST_NOT_FOUND;
    else begin
      unique case (req_q)
        REQ_RESERVE: begin
          if (es != SLOT_ENCODING) st = ST_WRONG_STATE;
          else if (ep >= PcW'(PagesPerSlot)) st = ST_PAGE_LIMIT;
          else if (nr[64] || ni[64]) st = ST_OVERFLOW;
          else if (ni[63:0] > max_inf_q) st = ST_INFLIGHT_CAP;
          else if (nr[63:0] > max_sub_q) st = ST_SUB_CAP;
        end
        REQ_CANCEL: begin
          if (es != SLOT_ENCODING) st = ST_WRONG_STATE;
          else if (ep == 0 || ep > PcW'(PagesPerSlot)) st = ST_CANCEL_MIS;
          else if (last_q != amt_q) st = ST_CANCEL_MIS;
          else if (last_q > er || last_q > inf_r_q || el > er - last_q) st = ST_CANCEL_MIS;
        end
        REQ_RECORD: begin
          if (es != SLOT_ENCODING) st = ST_WRONG_STATE;
          else if (nl[64]) st = ST_OVERFLOW;
          else if (nl[63:0] > er) st = ST_LOG_EXCEEDS;
          else if (nil[64]) st = ST_OVERFLOW;
          else if (sbc_q[hs_q] == BufMax) st = ST_OVERFLOW;
        end
        REQ_SUBMIT: begin
          if (es != SLOT_ENCODING || enc_q == 0) st = ST_WRONG_STATE;
        end
        REQ_COMPLETE: begin
          if (es != SLOT_SUBMITTED) st = ST_WRONG_STATE;
        end
        REQ_ABANDON: begin
          if (es != SLOT_ENCODING && es != SLOT_SUBMITTED) st = ST_WRONG_STATE;
        end
        default: st = ST_OK;
      endcase
    end
  end

  logic do_it;
  assign do_it = cmd_i.exec && (st == ST_OK) && req_q < REQ_QUERY;

  // page memory write on reserve
  always_ff @(posedge clk_i) begin
    if (do_it && req_q == REQ_RESERVE) begin
      page_mem[{hs_q, PageW'(ep)}] <= amt_q;
    end
  end

  // control and table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_inf_q <= RstMaxInflight;
      max_sub_q <= RstMaxPerSub;
      max_cnt_q <= RstMaxSubs;
      for (int i = 0; i < Slots; i++) begin
        sst_q[i] <= SLOT_EMPTY;
        sid_q[i] <= '0;
        srs_q[i] <= '0;
        slg_q[i] <= '0;
        spc_q[i] <= '0;
        sbc_q[i] <= '0;
      end
      inf_r_q <= '0;
      inf_l_q <= '0;
      pk_r_q <= '0;
      pk_l_q <= '0;
      enc_q <= '0;
      sub_q <= '0;
      pk_a_q <= '0;
    end else begin
      // configuration writes
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          CfgMaxInflight: max_inf_q <= cfg_data_i;
          CfgMaxPerSub:   max_sub_q <= cfg_data_i;
          CfgMaxSubs:     max_cnt_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.exec && req_q == REQ_CLEAR) begin
        for (int i = 0; i < Slots; i++) begin
          sst_q[i] <= SLOT_EMPTY;
          sid_q[i] <= '0;
          srs_q[i] <= '0;
          slg_q[i] <= '0;
          spc_q[i] <= '0;
          sbc_q[i] <= '0;
        end
        inf_r_q <= '0;
        inf_l_q <= '0;
        pk_r_q <= '0;
        pk_l_q <= '0;
        enc_q <= '0;
        sub_q <= '0;
        pk_a_q <= '0;
      end else if (do_it) begin
        unique case (req_q) inside
          REQ_BEGIN: begin
            sst_q[fs_q] <= SLOT_ENCODING;
            sid_q[fs_q] <= id_q;
            srs_q[fs_q] <= '0;
            slg_q[fs_q] <= '0;
            spc_q[fs_q] <= '0;
            sbc_q[fs_q] <= '0;
            enc_q <= enc_q + 1'b1;
            if (act[CntW-1:0] + 1'b1 > pk_a_q) pk_a_q <= act[CntW-1:0] + 1'b1;
          end
          REQ_RESERVE: begin
            spc_q[hs_q] <= ep + 1'b1;
            srs_q[hs_q] <= nr[63:0];
            inf_r_q <= ni[63:0];
            if (ni[63:0] > pk_r_q) pk_r_q <= ni[63:0];
          end
          REQ_CANCEL: begin
            srs_q[hs_q] <= er - last_q;
            inf_r_q <= inf_r_q - last_q;
            spc_q[hs_q] <= ep - 1'b1;
          end
          REQ_RECORD: begin
            slg_q[hs_q] <= nl[63:0];
            inf_l_q <= nil[63:0];
            if (nil[63:0] > pk_l_q) pk_l_q <= nil[63:0];
            sbc_q[hs_q] <= sbc_q[hs_q] + 1'b1;
          end
          REQ_SUBMIT: begin
            sst_q[hs_q] <= SLOT_SUBMITTED;
            enc_q <= enc_q - 1'b1;
            sub_q <= sub_q + 1'b1;
          end
          REQ_COMPLETE, REQ_ABANDON: begin
            inf_r_q <= (er <= inf_r_q) ? inf_r_q - er : '0;
            inf_l_q <= (el <= inf_l_q) ? inf_l_q - el : '0;
            if (es == SLOT_ENCODING && enc_q != 0) enc_q <= enc_q - 1'b1;
            if (es == SLOT_SUBMITTED && sub_q != 0) sub_q <= sub_q - 1'b1;
            sst_q[hs_q] <= SLOT_EMPTY;
            sid_q[hs_q] <= '0;
            srs_q[hs_q] <= '0;
            slg_q[hs_q] <= '0;
            spc_q[hs_q] <= '0;
            sbc_q[hs_q] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // request capture and lookup registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      id_q <= submission_id_i;
      amt_q <= byte_amount_i;
    end
    if (cmd_i.lookup) begin
      hit_q <= hit_c;
      hs_q <= hs_c;
      free_ok_q <= free_c;
      fs_q <= fs_c;
    end
    if (cmd_i.exec) begin
      status_q <= st;
    end
  end

  // response: totals and the named entry after the command
  assign status_o = status_q;
  assign total_reserved_o = inf_r_q;
  assign total_logical_o = inf_l_q;
  assign peak_reserved_o = pk_r_q;
  assign peak_logical_o = pk_l_q;
  assign encoding_count_o = 4'(enc_q);
  assign submitted_count_o = 4'(sub_q);
  assign peak_active_o = 4'(pk_a_q);
  assign entry_state_o = hit_c ? sst_q[hs_c] : 2'd0;
  assign entry_reserved_o = hit_c ? srs_q[hs_c] : 64'd0;
  assign entry_logical_o = hit_c ? slg_q[hs_c] : 64'd0;
  assign entry_pages_o = hit_c ? 5'(spc_q[hs_c]) : 5'd0;

endmodule
`default_nettype wire

[rtl/submission_byte_budget_tracker_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// submission_byte_budget_tracker_core
// budget bookkeeping for scratch memory of in-flight submissions
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid_i / req_ready_o) carries one command request:
//   req_type_i, submission_id_i, byte_amount_i.
//   rsp channel (rsp_valid_o / rsp_ready_i) returns one result per request:
//   status, global totals, peaks, slot counts and the named entry.
//   cfg channel writes limit registers by index; it is always ready and
//   should only be used while no request is in flight.
//   a request passes capture, id match and page memory read, check and
//   commit, then the response; one request at a time, so no new request is
//   accepted until the response is taken. The id match over the slot table
//   and the registered page memory read share a state of their own, lookup.
//   reset: limits return to defaults, all slots empty, totals and peaks zero.
//   page memory needs no clearing, a page is written before it is read.
//   a stalled response holds its fields until taken; no new request is
//   accepted meanwhile.
// ----------------------------------------------------------------------------
module submission_byte_budget_tracker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic [3:0]  req_type_i,
  input  wire logic [63:0] submission_id_i,
  input  wire logic [63:0] byte_amount_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_ready_i,
  output logic [3:0]       status_o,
  output logic [63:0]      total_reserved_o,
  output logic [63:0]      total_logical_o,
  output logic [63:0]      peak_reserved_o,
  output logic [63:0]      peak_logical_o,
  output logic [3:0]       encoding_count_o,
  output logic [3:0]       submitted_count_o,
  output logic [3:0]       peak_active_o,
  output logic [1:0]       entry_state_o,
  output logic [63:0]      entry_reserved_o,
  output logic [63:0]      entry_logical_o,
  output logic [4:0]       entry_pages_o
);
  import sbbt_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // sequencer
  sbbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .cmd_o       (cmd)
  );

  // datapath
  sbbt_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_data_i        (cfg_data_i),
    .req_type_i        (req_type_i),
    .submission_id_i   (submission_id_i),
    .byte_amount_i     (byte_amount_i),
    .status_o          (status_o),
    .total_reserved_o  (total_reserved_o),
    .total_logical_o   (total_logical_o),
    .peak_reserved_o   (peak_reserved_o),
    .peak_logical_o    (peak_logical_o),
    .encoding_count_o  (encoding_count_o),
    .submitted_count_o (submitted_count_o),
    .peak_active_o     (peak_active_o),
    .entry_state_o     (entry_state_o),
    .entry_reserved_o  (entry_reserved_o),
    .entry_logical_o   (entry_logical_o),
    .entry_pages_o     (entry_pages_o)
  );

  // a request is never accepted while a response is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(req_ready_o && rsp_valid_o))
    else $error("request accepted during pending response");

  // response follows an accepted request after the lookup and execute states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |-> ##3 rsp_valid_o)
    else $error("response latency broken");

  // active slots never exceed slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, encoding_count_o} + {1'b0, submitted_count_o}) <= 5'(Slots))
    else $error("active slot count above table size");

endmodule
`default_nettype wire
